// File: src/assert_macros.svh
// Assertion macros used by the unescaper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define JSAU_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define JSAU_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define JSAU_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: src/jsau_pkg.sv
// Types and codes shared by the JSON string array unescaper.
package jsau_pkg;

	typedef enum logic [3:0] {
		PH_BEFORE_OPEN,
		PH_AFTER_OPEN,
		PH_AFTER_COMMA,
		PH_IN_STRING,
		PH_ESCAPE,
		PH_HEX_FIRST,
		PH_WANT_BACKSLASH,
		PH_WANT_U,
		PH_HEX_SECOND,
		PH_AFTER_STRING,
		PH_TRAILING,
		PH_DONE,
		PH_FAILED
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_END_STRING,
		KIND_ARRAY_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE,
		ERR_BAD_OPEN,
		ERR_EXPECT_STRING,
		ERR_EXPECT_SEP,
		ERR_TRAILING,
		ERR_EARLY_END,
		ERR_CONTROL,
		ERR_BAD_ESCAPE,
		ERR_BAD_HEX,
		ERR_MISSING_LOW,
		ERR_BAD_LOW,
		ERR_LONE_LOW
	} err_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] hex_value;
		logic [1:0]  hex_count;
		logic [9:0]  high_sur;
	} parse_state_t;

	typedef struct packed {
		logic [2:0]      n;
		kind_t           kind;
		err_t            err;
		logic [3:0][7:0] bytes;
	} step_result_t;

	localparam int unsigned MaxResults = 4;

endpackage

// File: src/jsau_step.sv
// Parser transition and UTF-8 encoding for one input item.
module jsau_step (
	input  jsau_pkg::parse_state_t cs,
	input  logic                   command,
	input  logic [7:0]             in_byte,
	output jsau_pkg::parse_state_t ns,
	output jsau_pkg::step_result_t res
);
	import jsau_pkg::*;

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
	endfunction

	logic        hex_ok;
	logic [3:0]  hex_digit;
	logic [15:0] hv;
	err_t        err;
	logic        emit_byte;
	logic [7:0]  byte_val;
	logic        emit_cp;
	logic [20:0] cp;

	always_comb begin
		hex_ok    = 1'b1;
		hex_digit = 4'h0;
		if (in_byte >= "0" && in_byte <= "9") begin
			hex_digit = 4'(in_byte - "0");
		end else if (in_byte >= "a" && in_byte <= "f") begin
			hex_digit = 4'(in_byte - "a" + 8'd10);
		end else if (in_byte >= "A" && in_byte <= "F") begin
			hex_digit = 4'(in_byte - "A" + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
		hv = {cs.hex_value[11:0], hex_digit};
	end

	always_comb begin
		ns        = cs;
		err       = ERR_NONE;
		emit_byte = 1'b0;
		byte_val  = 8'h00;
		emit_cp   = 1'b0;
		cp        = '0;
		res       = '0;
		if (cs.phase != PH_DONE && cs.phase != PH_FAILED) begin
			if (command) begin
				unique case (cs.phase)
					PH_TRAILING: begin
						ns.phase = PH_DONE;
						res.n    = 3'd1;
						res.kind = KIND_ARRAY_DONE;
					end
					PH_AFTER_OPEN, PH_AFTER_COMMA: err = ERR_EXPECT_STRING;
					PH_AFTER_STRING:               err = ERR_EXPECT_SEP;
					PH_WANT_BACKSLASH, PH_WANT_U:  err = ERR_MISSING_LOW;
					default:                       err = ERR_EARLY_END;
				endcase
			end else begin
				unique case (cs.phase)
					PH_BEFORE_OPEN: begin
						if (in_byte == "[") ns.phase = PH_AFTER_OPEN;
						else if (!is_ws(in_byte)) err = ERR_BAD_OPEN;
					end
					PH_AFTER_OPEN, PH_AFTER_COMMA: begin
						if (is_ws(in_byte)) begin
						end else if (in_byte == "]" && cs.phase == PH_AFTER_OPEN) begin
							ns.phase = PH_TRAILING;
						end else if (in_byte == "\"") begin
							ns.phase = PH_IN_STRING;
						end else begin
							err = ERR_EXPECT_STRING;
						end
					end
					PH_IN_STRING: begin
						if (in_byte == "\"") begin
							ns.phase = PH_AFTER_STRING;
							res.n    = 3'd1;
							res.kind = KIND_END_STRING;
						end else if (in_byte < 8'h20) begin
							err = ERR_CONTROL;
						end else if (in_byte == "\\") begin
							ns.phase = PH_ESCAPE;
						end else begin
							emit_byte = 1'b1;
							byte_val  = in_byte;
						end
					end
					PH_ESCAPE: begin
						ns.phase  = PH_IN_STRING;
						emit_byte = 1'b1;
						case (in_byte)
							"\"", "\\", "/": byte_val = in_byte;
							"b": byte_val = 8'h08;
							"f": byte_val = 8'h0C;
							"n": byte_val = 8'h0A;
							"r": byte_val = 8'h0D;
							"t": byte_val = 8'h09;
							"u": begin
								emit_byte    = 1'b0;
								ns.phase     = PH_HEX_FIRST;
								ns.hex_value = '0;
								ns.hex_count = '0;
							end
							default: begin
								emit_byte = 1'b0;
								err       = ERR_BAD_ESCAPE;
							end
						endcase
					end
					PH_HEX_FIRST, PH_HEX_SECOND: begin
						if (!hex_ok) begin
							err = ERR_BAD_HEX;
						end else begin
							ns.hex_value = hv;
							ns.hex_count = cs.hex_count + 2'd1;
							if (cs.hex_count == 2'd3) begin
								if (cs.phase == PH_HEX_FIRST) begin
									if (hv[15:10] == 6'b110110) begin
										ns.high_sur = hv[9:0];
										ns.phase    = PH_WANT_BACKSLASH;
									end else if (hv[15:10] == 6'b110111) begin
										err = ERR_LONE_LOW;
									end else begin
										ns.phase = PH_IN_STRING;
										emit_cp  = 1'b1;
										cp       = {5'b0, hv};
									end
								end else if (hv[15:10] != 6'b110111) begin
									err = ERR_BAD_LOW;
								end else begin
									ns.phase = PH_IN_STRING;
									emit_cp  = 1'b1;
									cp       = 21'h10000 + {1'b0, cs.high_sur, hv[9:0]};
								end
							end
						end
					end
					PH_WANT_BACKSLASH: begin
						if (in_byte == "\\") ns.phase = PH_WANT_U;
						else err = ERR_MISSING_LOW;
					end
					PH_WANT_U: begin
						if (in_byte == "u") begin
							ns.phase     = PH_HEX_SECOND;
							ns.hex_value = '0;
							ns.hex_count = '0;
						end else begin
							err = ERR_MISSING_LOW;
						end
					end
					PH_AFTER_STRING: begin
						if (in_byte == ",") ns.phase = PH_AFTER_COMMA;
						else if (in_byte == "]") ns.phase = PH_TRAILING;
						else if (!is_ws(in_byte)) err = ERR_EXPECT_SEP;
					end
					PH_TRAILING: begin
						if (!is_ws(in_byte)) err = ERR_TRAILING;
					end
					default: begin
					end
				endcase
			end
		end

		if (err != ERR_NONE) begin
			ns.phase = PH_FAILED;
			res.n    = 3'd1;
			res.kind = KIND_ERROR;
			res.err  = err;
		end else if (emit_byte) begin
			res.n        = 3'd1;
			res.bytes[0] = byte_val;
		end else if (emit_cp) begin
			if (cp <= 21'h7F) begin
				res.n        = 3'd1;
				res.bytes[0] = cp[7:0];
			end else if (cp <= 21'h7FF) begin
				res.n        = 3'd2;
				res.bytes[0] = {3'b110, cp[10:6]};
				res.bytes[1] = {2'b10, cp[5:0]};
			end else if (cp <= 21'hFFFF) begin
				res.n        = 3'd3;
				res.bytes[0] = {4'b1110, cp[15:12]};
				res.bytes[1] = {2'b10, cp[11:6]};
				res.bytes[2] = {2'b10, cp[5:0]};
			end else begin
				res.n        = 3'd4;
				res.bytes[0] = {5'b11110, cp[20:18]};
				res.bytes[1] = {2'b10, cp[17:12]};
				res.bytes[2] = {2'b10, cp[11:6]};
				res.bytes[3] = {2'b10, cp[5:0]};
			end
		end
	end

endmodule

// File: src/json_string_array_unescaper.sv
// An accepted item waits in the input register until the result register is free.
// Throughput: one item per cycle while each item gives at most one result and
// out_stall stays low; a multi-byte UTF-8 item holds the single output register.
// Reset (arst_n low, asynchronous): parser returns to before the opening bracket,
// the input and result registers empty; an error or completion holds until reset.
`include "assert_macros.svh"

module json_string_array_unescaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [3:0] error_code,
	output logic       last
);
	import jsau_pkg::*;

	logic            valid_s1;
	logic            command_s1;
	logic [7:0]      byte_s1;
	parse_state_t    state_q;
	parse_state_t    state_next;
	step_result_t    res;
	logic [2:0]      cnt_q;
	kind_t           kind_q;
	err_t            err_q;
	logic [3:0][7:0] bytes_q;
	logic            out_take;
	logic            load;

	jsau_step u_step (
		.cs      (state_q),
		.command (command_s1),
		.in_byte (byte_s1),
		.ns      (state_next),
		.res     (res)
	);

	assign out_take = out_valid && !out_stall;
	assign load     = valid_s1 && (cnt_q == 3'd0 || (cnt_q == 3'd1 && out_take));
	assign in_stall = valid_s1 && !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			byte_s1    <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_BEFORE_OPEN;
			state_q.hex_value <= '0;
			state_q.hex_count <= '0;
			state_q.high_sur  <= '0;
			cnt_q             <= '0;
			kind_q            <= KIND_BYTE;
			err_q             <= ERR_NONE;
		end else if (load) begin
			state_q <= state_next;
			cnt_q   <= res.n;
			kind_q  <= res.kind;
			err_q   <= res.err;
		end else if (out_take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
		end else if (out_take) begin
			bytes_q <= {8'h00, bytes_q[3:1]};
		end
	end

	assign out_valid  = cnt_q != 3'd0;
	assign kind       = kind_q;
	assign out_byte   = bytes_q[0];
	assign error_code = err_q;
	assign last       = cnt_q == 3'd1;

	`JSAU_ASSERT_ALWAYS(a_cnt_range, cnt_q <= 3'(MaxResults))
	`JSAU_ASSERT_IMPL(a_load_free, load, cnt_q == 3'd0 || (cnt_q == 3'd1 && out_take))
	`JSAU_ASSERT_IMPL(a_error_single, out_valid && kind_q == KIND_ERROR, cnt_q == 3'd1)
	`JSAU_ASSERT_NEXT(a_fail_sticky, state_q.phase == PH_FAILED, state_q.phase == PH_FAILED)

endmodule

// File: sim/json_unescape_checker.sv
// Checker for the JSON string array unescaper: decodes accepted bytes and matches the results.
`timescale 1ns / 1ps

module json_unescape_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       command,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] kind,
	input  logic [7:0] out_byte,
	input  logic [3:0] error_code,
	input  logic       last,
	output int         mismatches,
	output int         pending,
	output int         checked
);
	import jsau_pkg::*;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		err_t       err;
		logic       last;
	} decoded_result_t;

	decoded_result_t awaited_q[$];
	decoded_result_t step_q[$];

	phase_t      phase;
	logic [15:0] hex_acc;
	logic [1:0]  hex_digits;
	logic [9:0]  high_half;
	logic        halted;

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, c[3:0]};
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			return {1'b1, 4'(c[3:0] + 4'd9)};
		return 5'd0;
	endfunction

	task automatic add_result(input kind_t k, input logic [7:0] d, input err_t e);
		decoded_result_t r;
		r.kind = k;
		r.data = d;
		r.err  = e;
		r.last = 1'b0;
		step_q = {step_q, r};
	endtask

	task automatic raise(input err_t e);
		halted = 1'b1;
		add_result(KIND_ERROR, 8'h00, e);
	endtask

	task automatic emit_utf8(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			add_result(KIND_BYTE, cp[7:0], ERR_NONE);
		end else if (cp <= 21'h7FF) begin
			add_result(KIND_BYTE, {3'b110, cp[10:6]}, ERR_NONE);
			add_result(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
		end else if (cp <= 21'hFFFF) begin
			add_result(KIND_BYTE, {4'b1110, cp[15:12]}, ERR_NONE);
			add_result(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
			add_result(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
		end else begin
			add_result(KIND_BYTE, {5'b11110, cp[20:18]}, ERR_NONE);
			add_result(KIND_BYTE, {2'b10, cp[17:12]}, ERR_NONE);
			add_result(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
			add_result(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
		end
	endtask

	task automatic decode_item(input logic cmd, input logic [7:0] c);
		logic [4:0] digit;
		if (halted)
			return;
		step_q.delete();
		if (cmd) begin
			case (phase)
				PH_TRAILING: begin
					phase  = PH_DONE;
					halted = 1'b1;
					add_result(KIND_ARRAY_DONE, 8'h00, ERR_NONE);
				end
				PH_AFTER_OPEN, PH_AFTER_COMMA: raise(ERR_EXPECT_STRING);
				PH_AFTER_STRING: raise(ERR_EXPECT_SEP);
				PH_WANT_BACKSLASH, PH_WANT_U: raise(ERR_MISSING_LOW);
				default: raise(ERR_EARLY_END);
			endcase
		end else begin
			case (phase)
				PH_BEFORE_OPEN: begin
					if (c == "[")
						phase = PH_AFTER_OPEN;
					else if (!is_blank(c))
						raise(ERR_BAD_OPEN);
				end
				PH_AFTER_OPEN, PH_AFTER_COMMA: begin
					if (c == "]" && phase == PH_AFTER_OPEN)
						phase = PH_TRAILING;
					else if (c == "\"")
						phase = PH_IN_STRING;
					else if (!is_blank(c))
						raise(ERR_EXPECT_STRING);
				end
				PH_IN_STRING: begin
					if (c == "\"") begin
						phase = PH_AFTER_STRING;
						add_result(KIND_END_STRING, 8'h00, ERR_NONE);
					end else if (c < 8'h20) begin
						raise(ERR_CONTROL);
					end else if (c == "\\") begin
						phase = PH_ESCAPE;
					end else begin
						add_result(KIND_BYTE, c, ERR_NONE);
					end
				end
				PH_ESCAPE: begin
					phase = PH_IN_STRING;
					case (c)
						"\"", "\\", "/": add_result(KIND_BYTE, c, ERR_NONE);
						"b": add_result(KIND_BYTE, 8'h08, ERR_NONE);
						"f": add_result(KIND_BYTE, 8'h0C, ERR_NONE);
						"n": add_result(KIND_BYTE, 8'h0A, ERR_NONE);
						"r": add_result(KIND_BYTE, 8'h0D, ERR_NONE);
						"t": add_result(KIND_BYTE, 8'h09, ERR_NONE);
						"u": begin
							phase      = PH_HEX_FIRST;
							hex_acc    = 16'h0000;
							hex_digits = 2'd0;
						end
						default: raise(ERR_BAD_ESCAPE);
					endcase
				end
				PH_HEX_FIRST, PH_HEX_SECOND: begin
					digit = hex_digit(c);
					if (!digit[4]) begin
						raise(ERR_BAD_HEX);
					end else begin
						hex_acc = {hex_acc[11:0], digit[3:0]};
						if (hex_digits != 2'd3) begin
							hex_digits = hex_digits + 2'd1;
						end else begin
							hex_digits = 2'd0;
							if (phase == PH_HEX_FIRST) begin
								if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
									high_half = hex_acc[9:0];
									phase     = PH_WANT_BACKSLASH;
								end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
									raise(ERR_LONE_LOW);
								end else begin
									phase = PH_IN_STRING;
									emit_utf8({5'd0, hex_acc});
								end
							end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
								raise(ERR_BAD_LOW);
							end else begin
								phase = PH_IN_STRING;
								emit_utf8(21'h10000 + {1'b0, high_half, hex_acc[9:0]});
							end
						end
					end
				end
				PH_WANT_BACKSLASH: begin
					if (c == "\\")
						phase = PH_WANT_U;
					else
						raise(ERR_MISSING_LOW);
				end
				PH_WANT_U: begin
					if (c == "u") begin
						phase      = PH_HEX_SECOND;
						hex_acc    = 16'h0000;
						hex_digits = 2'd0;
					end else begin
						raise(ERR_MISSING_LOW);
					end
				end
				PH_AFTER_STRING: begin
					if (c == ",")
						phase = PH_AFTER_COMMA;
					else if (c == "]")
						phase = PH_TRAILING;
					else if (!is_blank(c))
						raise(ERR_EXPECT_SEP);
				end
				PH_TRAILING: begin
					if (!is_blank(c))
						raise(ERR_TRAILING);
				end
				default: ;
			endcase
		end
		if (step_q.size() > 0) begin
			step_q[$].last = 1'b1;
			foreach (step_q[i])
				awaited_q = {awaited_q, step_q[i]};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_result_t want;
		if (!arst_n) begin
			phase      = PH_BEFORE_OPEN;
			hex_acc    = 16'h0000;
			hex_digits = 2'd0;
			high_half  = 10'd0;
			halted     = 1'b0;
			mismatches = 0;
			checked    = 0;
			awaited_q.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				decode_item(command, in_byte);
			if (out_valid && !out_stall) begin
				checked++;
				if (awaited_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result kind %0d byte %02h code %0d last %0d",
							$realtime, kind, out_byte, error_code, last);
				end else begin
					want = awaited_q.pop_front();
					if (kind !== want.kind || out_byte !== want.data ||
						error_code !== want.err || last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: expected kind %0d byte %02h code %0d last %0d,",
								" got kind %0d byte %02h code %0d last %0d"}, $realtime,
								want.kind, want.data, want.err, want.last,
								kind, out_byte, error_code, last);
					end
				end
			end
			pending <= awaited_q.size();
		end
	end

endmodule

// File: sim/json_string_array_unescaper_test.sv
// Top of the JSON string array unescaper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module json_string_array_unescaper_test;
	import jsau_pkg::*;

	typedef enum {
		END_CLEAN,
		END_TRAILING,
		END_NO_STRING,
		END_CONTROL,
		END_BAD_ESCAPE,
		END_BAD_HEX,
		END_NO_LOW,
		END_BAD_LOW,
		END_LONE_LOW,
		END_OPEN_STRING,
		END_NO_SEPARATOR
	} ending_t;

	localparam int DocItems      = 360;
	localparam int WatchdogLimit = 2000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       command;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [3:0] error_code;
	logic       last;
	int         mismatches;
	int         pending;
	int         checked;

	int unsigned idle_pct;
	int unsigned stall_pct = 0;
	int          items_sent;
	int          idle_cycles = 0;

	logic [7:0] blanks[4]  = '{8'h20, 8'h0A, 8'h0D, 8'h09};
	logic [7:0] escapes[8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

	json_string_array_unescaper DUT (.*);

	json_unescape_checker result_check (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic cmd, input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_item(1'b0, s[i]);
	endtask

	task automatic send_blanks(input int n);
		repeat (n)
			send_item(1'b0, blanks[$urandom_range(0, 3)]);
	endtask

	task automatic send_unicode(input logic [15:0] v);
		logic [3:0] nib;
		send_text("\\u");
		for (int i = 3; i >= 0; i--) begin
			nib = v[i * 4 +: 4];
			if (nib < 4'd10)
				send_item(1'b0, 8'h30 + nib);
			else
				send_item(1'b0, ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
		end
	endtask

	function automatic logic [9:0] pick_ten();
		case ($urandom_range(0, 3))
			0: return 10'h000;
			1: return 10'h3FF;
			default: return 10'($urandom);
		endcase
	endfunction

	task automatic send_piece();
		logic [7:0]  c;
		logic [15:0] cp;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				do
					c = 8'($urandom_range(32, 255));
				while (c == "\"" || c == "\\");
				send_item(1'b0, c);
			end
			5: begin
				send_item(1'b0, "\\");
				send_item(1'b0, escapes[$urandom_range(0, 7)]);
			end
			6, 7: begin
				case ($urandom_range(0, 7))
					0: cp = 16'h0000;
					1: cp = 16'h007F;
					2: cp = 16'h0080;
					3: cp = 16'h07FF;
					4: cp = 16'h0800;
					5: cp = 16'hFFFF;
					default: begin
						do
							cp = 16'($urandom);
						while (cp >= 16'hD800 && cp <= 16'hDFFF);
					end
				endcase
				send_unicode(cp);
			end
			default: begin
				send_unicode({6'b110110, pick_ten()});
				send_unicode({6'b110111, pick_ten()});
			end
		endcase
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		ending_t ending;
		int      r;
		int      doc_items;
		logic    drained;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = 1'b0;
		in_byte    = 8'h00;
		idle_pct   = 0;
		items_sent = 0;
		drained    = 1'b0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// leading whitespace, null escape and the highest surrogate pair
		send_text(" \t\n\r[ \"\\u0000\\uDBFF\\uDFFF\\n\"");

		while (items_sent < DocItems) begin
			if (items_sent < 90) begin
				idle_pct = 0;
				stall_pct <= 0;
			end else if (items_sent < 180) begin
				idle_pct = 55;
				stall_pct <= 0;
			end else if (items_sent < 270) begin
				if (!drained) begin
					wait_for_results();
					drained = 1'b1;
				end
				idle_pct = 0;
				stall_pct <= 55;
			end else begin
				idle_pct = 32;
				stall_pct <= 32;
			end
			send_blanks($urandom_range(0, 2));
			send_item(1'b0, ",");
			send_blanks($urandom_range(0, 2));
			send_item(1'b0, "\"");
			repeat ($urandom_range(0, 12))
				send_piece();
			send_item(1'b0, "\"");
		end

		r = $urandom_range(0, 13);
		ending = (r < 4) ? END_CLEAN : ending_t'(r - 3);
		case (ending)
			END_CLEAN: begin
				send_blanks($urandom_range(0, 2));
				send_item(1'b0, "]");
				send_blanks($urandom_range(0, 3));
				send_item(1'b1, 8'($urandom_range(0, 255)));
			end
			END_TRAILING: send_text("] x");
			END_NO_STRING: begin
				send_item(1'b0, ",");
				send_item(1'b1, 8'($urandom_range(0, 255)));
			end
			END_CONTROL: begin
				send_text(",\"a");
				send_item(1'b0, 8'($urandom_range(0, 31)));
			end
			END_BAD_ESCAPE: send_text(",\"\\q");
			END_BAD_HEX: send_text(",\"\\u1G");
			END_NO_LOW: begin
				send_text(",\"");
				send_unicode(16'hD83D);
				send_item(1'b1, 8'($urandom_range(0, 255)));
			end
			END_BAD_LOW: begin
				send_text(",\"");
				send_unicode(16'hD83D);
				send_unicode(16'h0041);
			end
			END_LONE_LOW: begin
				send_text(",\"");
				send_unicode(16'hDC01);
			end
			END_OPEN_STRING: begin
				send_text(",\"ab");
				send_item(1'b1, 8'($urandom_range(0, 255)));
			end
			default: send_text(" x");
		endcase

		// the block must stay silent from here on
		doc_items = items_sent;
		repeat (6)
			send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

		wait_for_results();
		repeat (8)
			@(posedge clk);

		$display("Drove %0d items as one string array plus %0d after it closed; %0d results checked.",
			doc_items, items_sent - doc_items, checked);
		$display("Ran free flow, sender gaps, receiver stalls and both; document closed by %s.",
			ending.name());
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
